/* hdl/nss_pkg.sv */
// Shared widths, codes, types and helpers for the nearest station list.
`default_nettype none

package nss_pkg;

    // Field widths fixed by the interface.
    localparam int SLOT_W    = 4;
    localparam int KEY_W     = 48;
    localparam int DIST_W    = 20;
    localparam int CRS_W     = 9;
    localparam int TIME_W    = 32;
    localparam int REQ_W     = 2;
    localparam int ACT_W     = 3;
    localparam int MIN_W     = 11;

    // The largest 11-bit minute count times 60000 ms stays below 2^27.
    localparam int TIMEOUT_W = 27;

    localparam int MS_PER_MINUTE = 60 * 1000;
    localparam int MINUTES_RESET = 30;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET =
        TIMEOUT_W'(MINUTES_RESET * MS_PER_MINUTE);

    localparam int NEAR_SLOTS_DEF = 4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_HEARD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PURGE_DUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PURGE_NOW = 2'd2;

    // Action codes reported with every result.
    localparam logic [ACT_W-1:0] ACT_UPDATED   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERTED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DISPLACED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PURGED    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NOT_DUE   = 3'd5;

    // Cell operation codes.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD    = 3'd0;
    localparam logic [OP_W-1:0] OP_HEARD   = 3'd1;
    localparam logic [OP_W-1:0] OP_PURGE   = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT    = 3'd3;
    localparam logic [OP_W-1:0] OP_COMPACT = 3'd4;
    localparam logic [OP_W-1:0] OP_ROTATE  = 3'd5;

    // One stored station.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DIST_W-1:0] distance;
        logic [CRS_W-1:0]  crs;
        logic [TIME_W-1:0] heard;
    } entry_t;

    // The fields of the item under work, broadcast to every cell.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DIST_W-1:0] distance;
        logic [CRS_W-1:0]  crs;
        logic [TIME_W-1:0] now;
    } item_t;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            phase;
    } ctrl_t;

    // Decide whether the adjacent pair (lower, upper) must trade places.
    // In sort mode a strictly farther station moves down; in compact mode
    // an empty slot moves down past a held one.
    function automatic logic swap_needed(input logic compact, input entry_t lower,
                                         input entry_t upper);
        logic result;
        if (compact)
        begin
            result = !lower.valid && upper.valid;
        end
        else
        begin
            result = lower.valid && upper.valid && (lower.distance > upper.distance);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* hdl/nearest_station_sorted_list.sv */
// Top level of the nearest station list: sequencer, cell chain and result register.
`default_nettype none

// Keeps up to NEAR_SLOTS heard stations sorted by ascending distance, empty
// slots at the end, in a chain of cells. Each accepted item is captured,
// evaluated (key match, insert or displace, or aging purge), then NEAR_SLOTS
// odd-even transposition passes run along the chain, and the list is read
// out as NEAR_SLOTS results, slot 0 first, by rotating the chain one place
// per result transfer. The readout gives one slot per cycle while the
// receiver takes each result, and holds while the receiver stalls. A new item
// is taken while the final result still waits in the output register.
// remember_minutes is written through cfg_we/cfg_data and is converted to
// a millisecond timeout on the write.

module nearest_station_sorted_list #(
    parameter int NEAR_SLOTS = nss_pkg::NEAR_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic [nss_pkg::MIN_W-1:0]     cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [nss_pkg::REQ_W-1:0]     req_type,
    input  wire logic [nss_pkg::KEY_W-1:0]     station_key,
    input  wire logic [nss_pkg::DIST_W-1:0]    distance_10m,
    input  wire logic [nss_pkg::CRS_W-1:0]     course_deg,
    input  wire logic [nss_pkg::TIME_W-1:0]    now_ms,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [nss_pkg::SLOT_W-1:0]         slot,
    output logic                               occupied,
    output logic [nss_pkg::KEY_W-1:0]          slot_key,
    output logic [nss_pkg::DIST_W-1:0]         slot_distance,
    output logic [nss_pkg::CRS_W-1:0]          slot_course,
    output logic [nss_pkg::ACT_W-1:0]          action,
    output logic                               last
);

    localparam int CNT_W = $clog2(NEAR_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NEAR_SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SORT = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic                            mode_reg;
    logic [nss_pkg::ACT_W-1:0]       act_reg;
    logic [nss_pkg::REQ_W-1:0]       req_reg;
    nss_pkg::item_t                  item_reg;
    logic [nss_pkg::TIME_W-1:0]      last_purge_reg;
    logic [nss_pkg::TIMEOUT_W-1:0]   timeout_reg;

    logic                            out_valid_reg;
    logic [nss_pkg::SLOT_W-1:0]      out_slot_reg;
    logic                            out_occ_reg;
    logic [nss_pkg::KEY_W-1:0]       out_key_reg;
    logic [nss_pkg::DIST_W-1:0]      out_dist_reg;
    logic [nss_pkg::CRS_W-1:0]       out_crs_reg;
    logic [nss_pkg::ACT_W-1:0]       out_act_reg;
    logic                            out_last_reg;

    nss_pkg::ctrl_t                  cell_ctrl;
    nss_pkg::entry_t                 entries [NEAR_SLOTS];
    logic [NEAR_SLOTS-1:0]           hit_vec;
    logic [NEAR_SLOTS-1:0]           valid_vec;
    logic                            any_hit;
    logic                            due;
    logic                            eval_heard;
    logic                            eval_purge;
    logic [nss_pkg::ACT_W-1:0]       eval_act;
    logic                            in_xfer;
    logic                            load;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign load     = (state_reg == ST_READ) && (!out_valid_reg || out_ready);
    assign any_hit  = |hit_vec;

    // Request decode during the evaluation cycle.
    assign due        = (item_reg.now - last_purge_reg) > nss_pkg::TIME_W'(timeout_reg);
    assign eval_heard = (req_reg == nss_pkg::REQ_HEARD);
    assign eval_purge = (req_reg == nss_pkg::REQ_PURGE_NOW) ||
                        ((req_reg == nss_pkg::REQ_PURGE_DUE) && due);

    // Outcome of the item, judged from the list before it changes.
    always_comb
    begin
        if (eval_heard)
        begin
            if (any_hit)
            begin
                eval_act = nss_pkg::ACT_UPDATED;
            end
            else if (!entries[NEAR_SLOTS-1].valid)
            begin
                eval_act = nss_pkg::ACT_INSERTED;
            end
            else if (entries[NEAR_SLOTS-1].distance > item_reg.distance)
            begin
                eval_act = nss_pkg::ACT_DISPLACED;
            end
            else
            begin
                eval_act = nss_pkg::ACT_DROPPED;
            end
        end
        else if (eval_purge)
        begin
            eval_act = nss_pkg::ACT_PURGED;
        end
        else
        begin
            eval_act = nss_pkg::ACT_NOT_DUE;
        end
    end

    // Sequencer: capture, evaluate, sort passes, readout.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cell_ctrl.op    = nss_pkg::OP_HOLD;
        cell_ctrl.phase = cnt_reg[0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (eval_heard)
                begin
                    cell_ctrl.op = nss_pkg::OP_HEARD;
                end
                else if (eval_purge)
                begin
                    cell_ctrl.op = nss_pkg::OP_PURGE;
                end
                cnt_next   = '0;
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                cell_ctrl.op = mode_reg ? nss_pkg::OP_COMPACT : nss_pkg::OP_SORT;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (load)
                begin
                    cell_ctrl.op = nss_pkg::OP_ROTATE;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            last_purge_reg <= '0;
            timeout_reg    <= nss_pkg::TIMEOUT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_EVAL) && eval_purge)
            begin
                last_purge_reg <= item_reg.now;
            end
            if (cfg_we)
            begin
                timeout_reg <= nss_pkg::TIMEOUT_W'(cfg_data * nss_pkg::MS_PER_MINUTE);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, outcome and result payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg           <= req_type;
            item_reg.key      <= station_key;
            item_reg.distance <= distance_10m;
            item_reg.crs      <= course_deg;
            item_reg.now      <= now_ms;
        end
        if (state_reg == ST_EVAL)
        begin
            act_reg  <= eval_act;
            mode_reg <= eval_purge;
        end
        if (load)
        begin
            out_slot_reg <= nss_pkg::SLOT_W'(cnt_reg);
            out_occ_reg  <= entries[0].valid;
            out_key_reg  <= entries[0].valid ? entries[0].key      : '0;
            out_dist_reg <= entries[0].valid ? entries[0].distance : '0;
            out_crs_reg  <= entries[0].valid ? entries[0].crs      : '0;
            out_act_reg  <= act_reg;
            out_last_reg <= (cnt_reg == CNT_LAST);
        end
    end

    // The chain of cells, closed into a ring for the readout rotation.
    for (genvar i = 0; i < NEAR_SLOTS; i++)
    begin : g_cell
        nss_cell #(
            .NEAR_SLOTS (NEAR_SLOTS),
            .CELL_INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .item        (item_reg),
            .timeout     (timeout_reg),
            .any_hit     (any_hit),
            .left_entry  (entries[(i + NEAR_SLOTS - 1) % NEAR_SLOTS]),
            .right_entry (entries[(i + 1) % NEAR_SLOTS]),
            .entry       (entries[i]),
            .hit         (hit_vec[i])
        );
        assign valid_vec[i] = entries[i].valid;
    end

    assign out_valid     = out_valid_reg;
    assign slot          = out_slot_reg;
    assign occupied      = out_occ_reg;
    assign slot_key      = out_key_reg;
    assign slot_distance = out_dist_reg;
    assign slot_course   = out_crs_reg;
    assign action        = out_act_reg;
    assign last          = out_last_reg;

    // Between items the held stations form an unbroken run from slot 0.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        ((valid_vec & (valid_vec + {{(NEAR_SLOTS-1){1'b0}}, 1'b1})) == '0))
        else $error("held stations are not contiguous from slot 0");

    // Between items the held stations are in ascending distance.
    for (genvar j = 0; j < NEAR_SLOTS - 1; j++)
    begin : g_sorted_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            ((state_reg == ST_IDLE) && entries[j + 1].valid) |->
            (entries[j].distance <= entries[j + 1].distance))
            else $error("list is not sorted by distance");
    end

    // The closing result of a readout reports the final slot.
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (slot == nss_pkg::SLOT_W'(NEAR_SLOTS - 1)))
        else $error("last flag on a slot other than the final one");

    // A readout in progress follows each taken result with the next one.
    a_readout_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("readout stopped before the final slot");

endmodule

`default_nettype wire

/* hdl/nss_cell.sv */
// One list cell: holds a station and trades it with its neighbors.
`default_nettype none

module nss_cell #(
    parameter int NEAR_SLOTS = nss_pkg::NEAR_SLOTS_DEF,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire nss_pkg::ctrl_t                 ctrl,
    input  wire nss_pkg::item_t                 item,
    input  wire logic [nss_pkg::TIMEOUT_W-1:0]  timeout,
    input  wire logic                           any_hit,
    input  wire nss_pkg::entry_t                left_entry,
    input  wire nss_pkg::entry_t                right_entry,
    output nss_pkg::entry_t                     entry,
    output logic                                hit
);

    localparam bit IS_FIRST = (CELL_INDEX == 0);
    localparam bit IS_LAST  = (CELL_INDEX == NEAR_SLOTS - 1);
    localparam bit PARITY   = 1'(CELL_INDEX % 2);

    nss_pkg::entry_t entry_reg;
    nss_pkg::entry_t entry_next;

    logic                          write_slot;
    logic                          aged;
    logic [nss_pkg::TIME_W-1:0]    age;
    logic                          lower_of_pair;
    logic                          upper_of_pair;
    logic                          compact;

    // Key match against a held station.
    assign hit = entry_reg.valid && (entry_reg.key == item.key);

    // A new station lands in the first empty slot, or in the last slot when
    // the list is full and the last station is strictly farther.
    assign write_slot = (!entry_reg.valid && (IS_FIRST || left_entry.valid)) ||
                        (IS_LAST && entry_reg.valid && (entry_reg.distance > item.distance));

    // Age test with wrapping time.
    assign age  = item.now - entry_reg.heard;
    assign aged = entry_reg.valid && (age > nss_pkg::TIME_W'(timeout));

    // Pairing for the odd-even transposition passes.
    assign lower_of_pair = (ctrl.phase == PARITY) && !IS_LAST;
    assign upper_of_pair = (ctrl.phase != PARITY) && !IS_FIRST;
    assign compact       = (ctrl.op == nss_pkg::OP_COMPACT);

    // Next contents of the cell.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            nss_pkg::OP_HEARD:
            begin
                if (hit)
                begin
                    entry_next.heard    = item.now;
                    entry_next.distance = item.distance;
                end
                else if (!any_hit && write_slot)
                begin
                    entry_next.valid    = 1'b1;
                    entry_next.key      = item.key;
                    entry_next.distance = item.distance;
                    entry_next.crs      = item.crs;
                    entry_next.heard    = item.now;
                end
            end
            nss_pkg::OP_PURGE:
            begin
                if (aged)
                begin
                    entry_next.valid = 1'b0;
                end
            end
            nss_pkg::OP_SORT, nss_pkg::OP_COMPACT:
            begin
                if (lower_of_pair && nss_pkg::swap_needed(compact, entry_reg, right_entry))
                begin
                    entry_next = right_entry;
                end
                else if (upper_of_pair &&
                         nss_pkg::swap_needed(compact, left_entry, entry_reg))
                begin
                    entry_next = left_entry;
                end
            end
            nss_pkg::OP_ROTATE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Cell register; reset leaves an empty slot with cleared fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the nearest station sorted list with an in-bench list model.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nss_pkg::*;

    localparam int NS = NEAR_SLOTS_DEF;
    // Sort passes plus the readout, with some margin.
    localparam int DRAIN_CYCLES = 2 * NS + 4;
    localparam int DIRECTED_ROWS = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NO_EVENT = -1;

    // The one request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MAX = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [CRS_W-1:0] CRS_MAX = 9'd359;

    // Station keys used by the directed rows.
    localparam logic [KEY_W-1:0] KEY_A = 48'h8A4C_3B21_0F65;
    localparam logic [KEY_W-1:0] KEY_B = 48'h5173_E0D4_9C8A;
    localparam logic [KEY_W-1:0] KEY_C = 48'h2E96_7D0B_41F3;
    localparam logic [KEY_W-1:0] KEY_D = 48'hC0FF_1234_5678;
    localparam logic [KEY_W-1:0] KEY_E = 48'h0B1D_A5E7_3C92;
    localparam logic [KEY_W-1:0] KEY_F = 48'h7F00_00FF_AA55;

    // One slot of a list readout as the block should report it.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              occupied;
        logic [KEY_W-1:0]  key;
        logic [DIST_W-1:0] distance;
        logic [CRS_W-1:0]  crs;
        logic [ACT_W-1:0]  act;
        logic              last;
    } readout_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [KEY_W-1:0]  key;
        logic [DIST_W-1:0] distance;
        logic [CRS_W-1:0]  crs;
        logic [TIME_W-1:0] now;
        logic              typed;
        logic [ACT_W-1:0]  act;
    } request_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [MIN_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type = '0;
    logic [KEY_W-1:0]  station_key = '0;
    logic [DIST_W-1:0] distance_10m = '0;
    logic [CRS_W-1:0]  course_deg = '0;
    logic [TIME_W-1:0] now_ms = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SLOT_W-1:0] slot;
    logic              occupied;
    logic [KEY_W-1:0]  slot_key;
    logic [DIST_W-1:0] slot_distance;
    logic [CRS_W-1:0]  slot_course;
    logic [ACT_W-1:0]  action;
    logic              last;

    // Model of the station list and its registers.
    entry_t            stations [NS];
    logic [TIME_W-1:0] last_purge_ms;
    logic [MIN_W-1:0]  memory_minutes;
    readout_t          pending_readouts [$];

    request_row_t      directed [DIRECTED_ROWS];
    logic [KEY_W-1:0]  key_pool [8];
    logic [DIST_W-1:0] dist_pool [6];
    logic [TIME_W-1:0] clock_ms;

    int failures = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    nearest_station_sorted_list #(
        .NEAR_SLOTS(NS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .station_key(station_key),
        .distance_10m(distance_10m),
        .course_deg(course_deg),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot(slot),
        .occupied(occupied),
        .slot_key(slot_key),
        .slot_distance(slot_distance),
        .slot_course(slot_course),
        .action(action),
        .last(last)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [TIME_W-1:0] timeout_ms();
        return TIME_W'(memory_minutes) * TIME_W'(MS_PER_MINUTE);
    endfunction

    // Stable bubble sort of the held stations by distance.
    function automatic void sort_by_distance();
        entry_t swap;
        for (int e = 0; e < NS - 1; e++)
        begin
            for (int f = 0; f < NS - e - 1; f++)
            begin
                if (stations[f].valid && stations[f + 1].valid &&
                    stations[f].distance > stations[f + 1].distance)
                begin
                    swap = stations[f];
                    stations[f] = stations[f + 1];
                    stations[f + 1] = swap;
                end
            end
        end
    endfunction

    // Clear aged entries, then move the empty slots to the end.
    function automatic void purge_aged(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] to_ms;
        logic [TIME_W-1:0] age;
        entry_t swap;
        to_ms = timeout_ms();
        for (int a = 0; a < NS; a++)
        begin
            age = now - stations[a].heard;
            if (stations[a].valid && age > to_ms)
            begin
                stations[a] = '0;
            end
        end
        for (int b = 0; b < NS - 1; b++)
        begin
            for (int c = 0; c < NS - b - 1; c++)
            begin
                if (!stations[c].valid)
                begin
                    swap = stations[c];
                    stations[c] = stations[c + 1];
                    stations[c + 1] = swap;
                end
            end
        end
        last_purge_ms = now;
    endfunction

    // A heard station: refresh, fill a free slot, displace a farther one, or drop.
    function automatic logic [ACT_W-1:0] record_heard(input logic [KEY_W-1:0] key,
                                                      input logic [DIST_W-1:0] distance,
                                                      input logic [CRS_W-1:0] crs,
                                                      input logic [TIME_W-1:0] now);
        for (int i = 0; i < NS; i++)
        begin
            if (stations[i].valid && stations[i].key == key)
            begin
                stations[i].heard = now;
                if (stations[i].distance != distance)
                begin
                    stations[i].distance = distance;
                    sort_by_distance();
                end
                return ACT_UPDATED;
            end
        end
        for (int i = 0; i < NS; i++)
        begin
            if (!stations[i].valid)
            begin
                stations[i] = {1'b1, key, distance, crs, now};
                sort_by_distance();
                return ACT_INSERTED;
            end
        end
        for (int i = 0; i < NS; i++)
        begin
            if (stations[i].distance > distance)
            begin
                for (int d = NS - 1; d > i; d--)
                begin
                    stations[d] = stations[d - 1];
                end
                stations[i] = {1'b1, key, distance, crs, now};
                return ACT_DISPLACED;
            end
        end
        return ACT_DROPPED;
    endfunction

    // Apply one request to the model and return the action it reports.
    function automatic logic [ACT_W-1:0] update_station_list(input logic [REQ_W-1:0] req,
                                                             input logic [KEY_W-1:0] key,
                                                             input logic [DIST_W-1:0] distance,
                                                             input logic [CRS_W-1:0] crs,
                                                             input logic [TIME_W-1:0] now);
        logic [ACT_W-1:0] act;
        logic [TIME_W-1:0] since_purge;
        act = ACT_NOT_DUE;
        since_purge = now - last_purge_ms;
        case (req)
            REQ_HEARD:
            begin
                act = record_heard(key, distance, crs, now);
            end
            REQ_PURGE_DUE:
            begin
                if (since_purge > timeout_ms())
                begin
                    purge_aged(now);
                    act = ACT_PURGED;
                end
            end
            REQ_PURGE_NOW:
            begin
                purge_aged(now);
                act = ACT_PURGED;
            end
            default:
            begin
                act = ACT_NOT_DUE;
            end
        endcase
        return act;
    endfunction

    // Queue the full readout of the list that follows one request.
    function automatic void queue_readouts(input logic [ACT_W-1:0] act);
        readout_t r;
        for (int k = 0; k < NS; k++)
        begin
            r.slot = SLOT_W'(k);
            r.occupied = stations[k].valid;
            r.key = stations[k].valid ? stations[k].key : '0;
            r.distance = stations[k].valid ? stations[k].distance : '0;
            r.crs = stations[k].valid ? stations[k].crs : '0;
            r.act = act;
            r.last = (k == NS - 1);
            pending_readouts.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Offer one request, hold it until the transfer, then predict its readout.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                                input logic [DIST_W-1:0] distance,
                                input logic [CRS_W-1:0] crs,
                                input logic [TIME_W-1:0] now, input logic typed,
                                input logic [ACT_W-1:0] typed_act);
        logic [ACT_W-1:0] act;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        station_key <= key;
        distance_10m <= distance;
        course_deg <= crs;
        now_ms <= now;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        act = update_station_list(req, key, distance, crs, now);
        queue_readouts(typed ? typed_act : act);
    endtask

    // Random request, mostly heard stations from a small key pool so keys recur.
    task automatic send_random();
        int unsigned pick;
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [DIST_W-1:0] distance;
        logic [CRS_W-1:0] crs;
        logic [TIME_W-1:0] to_ms;
        to_ms = timeout_ms();
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            req = REQ_HEARD;
        end
        else if (pick < 82)
        begin
            req = REQ_PURGE_DUE;
        end
        else if (pick < 94)
        begin
            req = REQ_PURGE_NOW;
        end
        else
        begin
            req = REQ_UNUSED;
        end
        key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 7)]
                                          : KEY_W'({$urandom(), $urandom()});
        distance = ($urandom_range(0, 1) != 0) ? dist_pool[$urandom_range(0, 5)]
                                               : DIST_W'($urandom());
        crs = CRS_W'($urandom_range(0, 359));
        // Time mostly creeps forward, sometimes past the timeout, now and then jumps.
        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            clock_ms = clock_ms + $urandom_range(0, to_ms / 4 + 3);
        end
        else if (pick < 95)
        begin
            clock_ms = clock_ms + $urandom_range(to_ms / 2, to_ms + to_ms / 2 + 2);
        end
        else
        begin
            clock_ms = $urandom();
        end
        send_request(req, key, distance, crs, clock_ms, 1'b0, ACT_UPDATED);
    endtask

    // Wait until every predicted slot has arrived, checking the queue only after waiting on the clock.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_readouts.size() != 0);
    endtask

    // Change the memory time only once the block has gone idle.
    task automatic write_memory(input logic [MIN_W-1:0] minutes);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= minutes;
        @(posedge clk);
        cfg_we <= 1'b0;
        memory_minutes = minutes;
    endtask

    // One random phase: a memory setting, an idling pattern and optional pressure points.
    task automatic run_phase(input logic [MIN_W-1:0] minutes, input int idle_pct,
                             input int stall_pct, input int count, input int hold_at,
                             input int pause_at);
        write_memory(minutes);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
            begin
                hold_cycles = HOLD_OFF_CYCLES;
            end
            if (n == pause_at)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            send_random();
        end
        in_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off counted down here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare every result transfer with the oldest predicted slot.
    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readouts.size() == 0)
            begin
                $error("result for slot %0d arrived with nothing pending", slot);
                failures++;
            end
            else
            begin
                want = pending_readouts.pop_front();
                check_field("slot", 64'(want.slot), 64'(slot));
                check_field("occupied", 64'(want.occupied), 64'(occupied));
                check_field("slot_key", 64'(want.key), 64'(slot_key));
                check_field("slot_distance", 64'(want.distance), 64'(slot_distance));
                check_field("slot_course", 64'(want.crs), 64'(slot_course));
                check_field("action", 64'(want.act), 64'(action));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        for (int i = 0; i < NS; i++)
        begin
            stations[i] = '0;
        end
        last_purge_ms = '0;
        memory_minutes = MIN_W'(MINUTES_RESET);
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < 8; i++)
        begin
            key_pool[i] = KEY_W'({$urandom(), $urandom()});
        end
        dist_pool[0] = '0;
        dist_pool[1] = 20'd1;
        dist_pool[2] = 20'd500;
        dist_pool[3] = 20'd1000;
        dist_pool[4] = 20'd70000;
        dist_pool[5] = DIST_MAX;

        // Empty list readouts, then fill, equal distances, displace and drop.
        directed[0] = '{REQ_PURGE_DUE, '0, '0, '0, 32'd0, 1'b1, ACT_NOT_DUE};
        directed[1] = '{REQ_UNUSED, KEY_MAX, DIST_MAX, CRS_MAX, 32'hFFFF_FFFF, 1'b1, ACT_NOT_DUE};
        directed[2] = '{REQ_HEARD, KEY_MAX, DIST_MAX, CRS_MAX, 32'd100, 1'b1, ACT_INSERTED};
        directed[3] = '{REQ_HEARD, '0, '0, '0, 32'd200, 1'b1, ACT_INSERTED};
        directed[4] = '{REQ_HEARD, KEY_A, 20'd500, 9'd90, 32'd300, 1'b0, ACT_UPDATED};
        directed[5] = '{REQ_HEARD, KEY_B, 20'd500, 9'd180, 32'd400, 1'b0, ACT_UPDATED};
        directed[6] = '{REQ_HEARD, KEY_C, 20'd500, 9'd270, 32'd500, 1'b1, ACT_DISPLACED};
        directed[7] = '{REQ_HEARD, KEY_D, DIST_MAX, 9'd1, 32'd600, 1'b1, ACT_DROPPED};
        // Refresh with the same distance, then with a new one; course stays.
        directed[8] = '{REQ_HEARD, KEY_A, 20'd500, 9'd5, 32'd700, 1'b1, ACT_UPDATED};
        directed[9] = '{REQ_HEARD, '0, 20'd2000, 9'd7, 32'd800, 1'b0, ACT_UPDATED};
        directed[10] = '{REQ_HEARD, KEY_E, '0, 9'd256, 32'd900, 1'b0, ACT_UPDATED};
        // Purge if due exactly at the timeout, then one past it.
        directed[11] = '{REQ_PURGE_DUE, '0, '0, '0, 32'd1_800_000, 1'b1, ACT_NOT_DUE};
        directed[12] = '{REQ_PURGE_DUE, '0, '0, '0, 32'd1_800_001, 1'b1, ACT_PURGED};
        directed[13] = '{REQ_HEARD, KEY_B, 20'd100, 9'd128, 32'd1_900_000, 1'b0, ACT_UPDATED};
        directed[14] = '{REQ_PURGE_NOW, '0, '0, '0, 32'd2_300_600, 1'b1, ACT_PURGED};
        // Key zero must not match a cleared slot.
        directed[15] = '{REQ_HEARD, '0, '0, 9'd64, 32'd2_300_700, 1'b0, ACT_UPDATED};
        // Ages across the wrap of the millisecond counter.
        directed[16] = '{REQ_HEARD, KEY_F, 20'd300, 9'd128, 32'hFFFF_FF00, 1'b0, ACT_UPDATED};
        directed[17] = '{REQ_PURGE_NOW, '0, '0, '0, 32'h0000_0100, 1'b1, ACT_PURGED};
        directed[18] = '{REQ_PURGE_DUE, '0, '0, '0, 32'h0000_0101, 1'b1, ACT_NOT_DUE};
        directed[19] = '{REQ_HEARD, KEY_F, 20'd300, 9'd33, 32'h0000_0200, 1'b1, ACT_UPDATED};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_request(directed[r].req, directed[r].key, directed[r].distance,
                         directed[r].crs, directed[r].now, directed[r].typed,
                         directed[r].act);
        end
        in_valid <= 1'b0;
        clock_ms = 32'h0000_0200;

        run_phase(MIN_W'(MINUTES_RESET), 0, 0, 70, NO_EVENT, NO_EVENT);
        run_phase(MIN_W'(0), 82, 0, 55, NO_EVENT, 30);
        run_phase(MIN_W'(1440), 0, 82, 55, NO_EVENT, NO_EVENT);
        run_phase(MIN_W'($urandom_range(2, 1439)), 9, 9, 70, NO_EVENT, 35);
        run_phase(MIN_W'(1), 0, 0, 70, 20, NO_EVENT);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_readouts.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
